// File: hw/rtl/countdown_timer_bank_defines.svh
// Assertion macros shared by the timer bank RTL.
`ifndef COUNTDOWN_TIMER_BANK_DEFINES_SVH
`define COUNTDOWN_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// Next-cycle implication, disabled during reset.
`define CTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

// File: hw/rtl/ctb_pkg.sv
package ctb_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W = $clog2(TIMER_COUNT + 1);
  localparam int VAL_W = 32;
  localparam int TIDX_W = 8;

  typedef enum logic [1:0] {
    CTB_OP_TICK  = 2'd0,
    CTB_OP_ALLOC = 2'd1,
    CTB_OP_SET   = 2'd2,
    CTB_OP_QUERY = 2'd3
  } ctb_op_t;

  typedef enum logic {
    CTB_EMPTY = 1'b0,
    CTB_FULL  = 1'b1
  } ctb_state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    ctb_op_t op;
    logic    reject;
  } ctb_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic index_ok;
    logic bank_full;
  } ctb_stat_t;

endpackage

// File: hw/rtl/ctb_cmd_if.sv
interface ctb_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic [ctb_pkg::TIDX_W-1:0]          timer_index;
  logic signed [ctb_pkg::VAL_W-1:0]    new_value;

  modport source (output valid, cmd, timer_index, new_value, input ready);
  modport sink (input valid, cmd, timer_index, new_value, output ready);
endinterface

// File: hw/rtl/ctb_rsp_if.sv
interface ctb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic [ctb_pkg::TIDX_W-1:0]          alloc_index;
  logic signed [ctb_pkg::VAL_W-1:0]    timer_value;
  logic                                expired;

  modport source (output valid, status, alloc_index, timer_value, expired, input ready);
  modport sink (input valid, status, alloc_index, timer_value, expired, output ready);
endinterface

// File: hw/rtl/ctb_ctrl.sv
module ctb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  input  ctb_pkg::ctb_stat_t stat,
  output ctb_pkg::ctb_ctrl_t ctrl
);

  ctb_pkg::ctb_state_t state;
  ctb_pkg::ctb_state_t state_next;
  ctb_pkg::ctb_op_t    op;
  logic                in_acc;

  assign op     = ctb_pkg::ctb_op_t'(in_cmd);
  assign in_acc = in_valid && in_ready;

  // Track whether the result register holds an untaken word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctb_pkg::CTB_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ctb_pkg::CTB_EMPTY: begin
        if (in_acc) state_next = ctb_pkg::CTB_FULL;
      end
      ctb_pkg::CTB_FULL: begin
        if (out_ready && !in_acc) state_next = ctb_pkg::CTB_EMPTY;
      end
      default: state_next = ctb_pkg::CTB_EMPTY;
    endcase
  end

  // Handshakes
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ctb_pkg::CTB_EMPTY: in_ready = 1'b1;
      ctb_pkg::CTB_FULL: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctrl.load   = in_acc;
    ctrl.op     = op;
    ctrl.reject = 1'b0;
    unique case (op)
      ctb_pkg::CTB_OP_TICK:  ctrl.reject = 1'b0;
      ctb_pkg::CTB_OP_ALLOC: ctrl.reject = stat.bank_full;
      ctb_pkg::CTB_OP_SET:   ctrl.reject = !stat.index_ok;
      ctb_pkg::CTB_OP_QUERY: ctrl.reject = !stat.index_ok;
      default:               ctrl.reject = 1'b1;
    endcase
  end

endmodule

// File: hw/rtl/ctb_datapath.sv
module ctb_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  ctb_pkg::ctb_ctrl_t                  ctrl,
  output ctb_pkg::ctb_stat_t                  stat,
  input  logic [ctb_pkg::TIDX_W-1:0]          timer_index,
  input  logic signed [ctb_pkg::VAL_W-1:0]    new_value,
  output logic                                status,
  output logic [ctb_pkg::TIDX_W-1:0]          alloc_index,
  output logic signed [ctb_pkg::VAL_W-1:0]    timer_value,
  output logic                                expired
);

  logic signed [ctb_pkg::VAL_W-1:0] timers      [ctb_pkg::TIMER_COUNT];
  logic signed [ctb_pkg::VAL_W-1:0] timers_next [ctb_pkg::TIMER_COUNT];
  logic [ctb_pkg::CNT_W-1:0]        count;
  logic [ctb_pkg::IDX_W-1:0]        sel;
  logic signed [ctb_pkg::VAL_W-1:0] rd_value;
  logic                             accept;

  assign sel      = timer_index[ctb_pkg::IDX_W-1:0];
  assign rd_value = timers[sel];
  assign accept   = ctrl.load && !ctrl.reject;

  assign stat.index_ok  = ({1'b0, timer_index} < (ctb_pkg::TIDX_W+1)'(ctb_pkg::TIMER_COUNT));
  assign stat.bank_full = (count == ctb_pkg::CNT_W'(ctb_pkg::TIMER_COUNT));

  // Per-lane update: decrement positive timers on tick, write on set
  always_comb begin
    for (int i = 0; i < ctb_pkg::TIMER_COUNT; i++) begin
      timers_next[i] = timers[i];
      if (accept && ctrl.op == ctb_pkg::CTB_OP_TICK && timers[i] > 0) begin
        timers_next[i] = timers[i] - 1;
      end else if (accept && ctrl.op == ctb_pkg::CTB_OP_SET
                   && sel == ctb_pkg::IDX_W'(i)) begin
        timers_next[i] = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ctb_pkg::TIMER_COUNT; i++) timers[i] <= '0;
    end else begin
      for (int i = 0; i < ctb_pkg::TIMER_COUNT; i++) timers[i] <= timers_next[i];
    end
  end

  // Advance the allocation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && ctrl.op == ctb_pkg::CTB_OP_ALLOC) begin
      count <= count + 1'b1;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      status      <= ctrl.reject;
      alloc_index <= '0;
      timer_value <= '0;
      expired     <= 1'b0;
      if (accept && ctrl.op == ctb_pkg::CTB_OP_ALLOC) begin
        alloc_index <= ctb_pkg::TIDX_W'(count);
      end
      if (accept && ctrl.op == ctb_pkg::CTB_OP_QUERY) begin
        timer_value <= rd_value;
        expired     <= (rd_value == '0);
      end
    end
  end

endmodule

// File: hw/rtl/countdown_timer_bank.sv
// Channel | Dir | Word fields
// req     | in  | cmd, timer_index, new_value
// rsp     | out | status, alloc_index, timer_value, expired
//
// Each command executes at the edge it is accepted and its result word is on rsp
// from the next cycle. A new command is taken every cycle while rsp takes each result word.
// All positive timers decrement in parallel in their own lanes on a tick.
// Reset clears all timers and the allocation counter; the block is ready at once.
// A held result word stalls req until rsp takes it.
`include "countdown_timer_bank_defines.svh"

module countdown_timer_bank (
  input  logic       clk,
  input  logic       rst,
  ctb_cmd_if.sink    req,
  ctb_rsp_if.source  rsp
);

  ctb_pkg::ctb_ctrl_t ctrl;
  ctb_pkg::ctb_stat_t stat;

  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (req.cmd),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ctb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .timer_index (req.timer_index),
    .new_value   (req.new_value),
    .status      (rsp.status),
    .alloc_index (rsp.alloc_index),
    .timer_value (rsp.timer_value),
    .expired     (rsp.expired)
  );

  // Checks
  `CTB_ASSERT_NOW(a_stall_blocks_req, clk, rst, rsp.valid && !rsp.ready, !req.ready)
  `CTB_ASSERT_NEXT(a_accept_gives_word, clk, rst, req.valid && req.ready, rsp.valid)
  `CTB_ASSERT_NOW(a_reject_clean, clk, rst, rsp.valid && rsp.status, rsp.alloc_index == '0 && rsp.timer_value == '0 && !rsp.expired)
  `CTB_ASSERT_NOW(a_expired_zero, clk, rst, rsp.valid && rsp.expired, rsp.timer_value == '0)

endmodule

// File: verif/tb_countdown_timer_bank.sv
module tb_countdown_timer_bank;
  import ctb_pkg::*;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;
  localparam int   PHASE_ITEMS = 340;
  localparam int   MAX_REPORTS = 40;

  typedef struct packed {
    logic                    status;
    logic [TIDX_W-1:0]       alloc_index;
    logic signed [VAL_W-1:0] timer_value;
    logic                    expired;
  } bank_rsp_t;

  typedef struct {
    ctb_op_t                 op;
    logic [TIDX_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
    int                      reps;
    bit                      fixed;
    bank_rsp_t               res;
  } stim_row_t;

  // Per-word note: a typed-in response overrides the prediction
  typedef struct {
    bit        fixed;
    bank_rsp_t res;
  } word_note_t;

  logic clk;
  logic rst;

  ctb_cmd_if cmd_bus ();
  ctb_rsp_if rsp_bus ();

  countdown_timer_bank uut (
    .clk (clk),
    .rst (rst),
    .req (cmd_bus.sink),
    .rsp (rsp_bus.source)
  );

  // Shadow state of the bank
  logic signed [VAL_W-1:0] shadow_timers [TIMER_COUNT];
  int                      granted_count;

  bank_rsp_t   pending_responses[$];
  word_note_t  word_notes[$];
  stim_row_t   directed_rows[$];
  int          error_count;
  int          src_idle_pct;
  int          snk_stall_pct;
  word_note_t  accepted_note;
  bank_rsp_t   predicted_rsp;
  bank_rsp_t   seen_rsp;
  bank_rsp_t   wanted_rsp;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(string what, bank_rsp_t got, bank_rsp_t want);
    if (error_count < MAX_REPORTS)
      $display("[%0t] %s: got st=%0d idx=%0d val=%0d exp=%0d, want st=%0d idx=%0d val=%0d exp=%0d",
               $realtime, what, got.status, got.alloc_index, got.timer_value, got.expired,
               want.status, want.alloc_index, want.timer_value, want.expired);
    error_count++;
  endtask

  // Execute one command on the shadow state and return its response word
  function automatic bank_rsp_t predict_response(ctb_op_t op, logic [TIDX_W-1:0] idx,
                                                 logic signed [VAL_W-1:0] val);
    bank_rsp_t r;
    r = '0;
    case (op)
      CTB_OP_TICK: begin
        for (int i = 0; i < TIMER_COUNT; i++)
          if (shadow_timers[i] > 0) shadow_timers[i] = shadow_timers[i] - 1;
      end
      CTB_OP_ALLOC: begin
        if (granted_count < TIMER_COUNT) begin
          r.alloc_index = TIDX_W'(granted_count);
          granted_count++;
        end else begin
          r.status = ST_REJECT;
        end
      end
      CTB_OP_SET: begin
        if (int'(idx) < TIMER_COUNT) shadow_timers[int'(idx)] = val;
        else r.status = ST_REJECT;
      end
      default: begin
        if (int'(idx) < TIMER_COUNT) begin
          r.timer_value = shadow_timers[int'(idx)];
          r.expired     = (shadow_timers[int'(idx)] == 0);
        end else begin
          r.status = ST_REJECT;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom_range(6);
    if (pick < 50) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return -1;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_row(ctb_op_t op, int idx, logic signed [VAL_W-1:0] val, int reps,
                         bit fixed, logic st, int aidx, logic signed [VAL_W-1:0] tval,
                         logic expd);
    stim_row_t row;
    row.op   = op;
    row.idx  = TIDX_W'(idx);
    row.val  = val;
    row.reps = reps;
    row.fixed = fixed;
    row.res  = '{status: st, alloc_index: TIDX_W'(aidx), timer_value: tval, expired: expd};
    directed_rows.push_back(row);
  endtask

  // Offer one command word; entered and left at a falling edge
  task automatic send_word(ctb_op_t op, logic [TIDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val, bit fixed, bank_rsp_t res);
    word_note_t note;
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    end
    note.fixed = fixed;
    note.res   = res;
    word_notes.push_back(note);
    cmd_bus.valid       <= 1'b1;
    cmd_bus.cmd         <= op;
    cmd_bus.timer_index <= idx;
    cmd_bus.new_value   <= val;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Response sink: stall at random
  always @(negedge clk)
    rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);

  // Check accepted responses, then predict the command taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        seen_rsp = '{status: rsp_bus.status, alloc_index: rsp_bus.alloc_index,
                     timer_value: rsp_bus.timer_value, expired: rsp_bus.expired};
        if (pending_responses.size() == 0) begin
          report_mismatch("response with nothing pending", seen_rsp, '0);
        end else begin
          wanted_rsp = pending_responses.pop_front();
          if (seen_rsp !== wanted_rsp) report_mismatch("response mismatch", seen_rsp, wanted_rsp);
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        accepted_note = word_notes.pop_front();
        predicted_rsp = predict_response(ctb_op_t'(cmd_bus.cmd), cmd_bus.timer_index,
                                         cmd_bus.new_value);
        pending_responses.push_back(accepted_note.fixed ? accepted_note.res : predicted_rsp);
      end
    end
  end

  initial begin
    #(8 * 600000);
    $display("tb_countdown_timer_bank: FAIL");
    $finish;
  end

  initial begin
    ctb_op_t                 op;
    logic [TIDX_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
    int                      pick;

    rst                 = 1'b1;
    cmd_bus.valid       = 1'b0;
    cmd_bus.cmd         = CTB_OP_TICK;
    cmd_bus.timer_index = '0;
    cmd_bus.new_value   = '0;
    rsp_bus.ready       = 1'b0;
    src_idle_pct        = 0;
    snk_stall_pct       = 0;
    error_count         = 0;
    granted_count       = 0;
    for (int i = 0; i < TIMER_COUNT; i++) shadow_timers[i] = '0;

    // Fresh bank, rejected indices, first grants, extreme values
    add_row(CTB_OP_QUERY, 0, 0, 1, 1, ST_OK, 0, 0, 1'b1);
    add_row(CTB_OP_QUERY, 15, 0, 1, 1, ST_OK, 0, 0, 1'b1);
    add_row(CTB_OP_QUERY, 16, 0, 1, 1, ST_REJECT, 0, 0, 1'b0);
    add_row(CTB_OP_QUERY, 255, 32'hFFFF_FFFF, 1, 1, ST_REJECT, 0, 0, 1'b0);
    add_row(CTB_OP_SET, 255, -1, 1, 1, ST_REJECT, 0, 0, 1'b0);
    add_row(CTB_OP_SET, 16, 5, 1, 1, ST_REJECT, 0, 0, 1'b0);
    add_row(CTB_OP_TICK, 0, 0, 1, 1, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_ALLOC, 0, 0, 1, 1, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_ALLOC, 0, 0, 1, 1, ST_OK, 1, 0, 1'b0);
    add_row(CTB_OP_SET, 0, 3, 1, 1, ST_OK, 0, 0, 1'b0);
    // Timer 15 is not allocated yet; the write still lands
    add_row(CTB_OP_SET, 15, 32'h7FFF_FFFF, 1, 1, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_SET, 1, 32'h8000_0000, 1, 1, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_SET, 2, -1, 1, 1, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_SET, 3, 1, 1, 1, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_TICK, 0, 0, 1, 1, ST_OK, 0, 0, 1'b0);
    // Negative timers hold, a timer reaching zero reads as expired
    add_row(CTB_OP_QUERY, 0, 0, 1, 0, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_QUERY, 15, 0, 1, 0, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_QUERY, 1, 0, 1, 0, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_QUERY, 2, 0, 1, 0, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_QUERY, 3, 0, 1, 0, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_TICK, 0, 0, 2, 1, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_QUERY, 0, 0, 1, 0, ST_OK, 0, 0, 1'b0);
    // Use up the remaining indices, then hit the full bank
    add_row(CTB_OP_ALLOC, 0, 0, 14, 0, ST_OK, 0, 0, 1'b0);
    add_row(CTB_OP_ALLOC, 0, 0, 1, 1, ST_REJECT, 0, 0, 1'b0);
    add_row(CTB_OP_QUERY, 14, 0, 1, 0, ST_OK, 0, 0, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_rows[r])
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_word(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].val,
                  directed_rows[r].fixed, directed_rows[r].res);

    // Random commands over the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
        default: begin src_idle_pct = 20; snk_stall_pct = 20; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 30)      op = CTB_OP_TICK;
        else if (pick < 40) op = CTB_OP_ALLOC;
        else if (pick < 70) op = CTB_OP_SET;
        else                op = CTB_OP_QUERY;
        idx = ($urandom_range(99) < 85) ? TIDX_W'($urandom_range(TIMER_COUNT - 1))
                                        : TIDX_W'($urandom_range(255));
        val = random_value();
        send_word(op, idx, val, 1'b0, '0);
      end
    end

    // Drain the outstanding responses
    cmd_bus.valid <= 1'b0;
    snk_stall_pct = 0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_countdown_timer_bank: PASS");
    end else begin
      $display("tb_countdown_timer_bank: FAIL");
    end
    $finish;
  end

endmodule
